// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define M4VT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define M4VT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/m4vt_pkg.sv -----
// Types and constants for the 4x4 matrix vector transform unit.
`timescale 1ns / 1ps
`default_nettype none

package m4vt_pkg;

    // Fraction bits of the Q format, Q16.16 by default.
    localparam int FRAC_BITS = 16;

    localparam int DATA_W = 32;
    localparam int DIM    = 4;
    localparam int NELEM  = DIM * DIM;

    // Command codes on the kind field.
    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_XFORM = 2'd1;
    localparam logic [1:0] KIND_IDENT = 2'd2;

    // Matrix value 1.0 in the fixed point format.
    localparam logic signed [DATA_W-1:0] FIX_ONE = DATA_W'(64'd1 << FRAC_BITS);

    typedef struct packed {
        logic [1:0]                kind;
        logic [1:0]                elem_row;
        logic [1:0]                elem_col;
        logic signed [DATA_W-1:0]  elem_value;
        logic signed [DATA_W-1:0]  vec_x;
        logic signed [DATA_W-1:0]  vec_y;
        logic signed [DATA_W-1:0]  vec_z;
        logic signed [DATA_W-1:0]  vec_w;
    } cmd_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  out_x;
        logic signed [DATA_W-1:0]  out_y;
        logic signed [DATA_W-1:0]  out_z;
        logic signed [DATA_W-1:0]  out_w;
    } res_t;

endpackage

`default_nettype wire

// ----- rtl/core/mat4_vector_transform_top.sv -----
// Top level of the 4x4 matrix vector transform unit (Q16.16).
`timescale 1ns / 1ps
`default_nettype none

// A transform beat accepted on cmd moves through the product, pair-sum and final
// sum/saturate registers to res; stalls hold it in place. Throughput: one beat per
// cycle of any kind while cmd_stall is low; every stage advances each cycle unless
// stalled, and the sixteen 32x32 multipliers ahead of the product register are the
// longest path. Loads and identity commands take effect at acceptance and are seen by
// every later transform. Reset (rst_n low, asynchronous) empties the pipeline and sets
// the matrix to identity.
module mat4_vector_transform_top (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    output logic                cmd_stall,
    input  wire m4vt_pkg::cmd_t cmd,
    output logic                res_valid,
    input  wire logic           res_stall,
    output m4vt_pkg::res_t      res
);

    localparam int DW     = m4vt_pkg::DATA_W;
    localparam int PROD_W = 2 * DW;      // full signed product
    localparam int PAIR_W = PROD_W + 1;  // sum of two products
    localparam int SUM_W  = PROD_W + 2;  // sum of four products, exact

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32'sh7FFF_FFFF);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(32'sh8000_0000);

    // Matrix, row-major, index row*4+col.
    logic signed [DW-1:0] matrix_reg  [m4vt_pkg::NELEM];
    logic signed [DW-1:0] matrix_next [m4vt_pkg::NELEM];

    // Stage 1: products.
    logic                     v1_reg, v1_next;
    logic signed [PROD_W-1:0] prod_reg  [m4vt_pkg::DIM][m4vt_pkg::DIM];
    logic signed [PROD_W-1:0] prod_next [m4vt_pkg::DIM][m4vt_pkg::DIM];

    // Stage 2: pair sums.
    logic                     v2_reg, v2_next;
    logic signed [PAIR_W-1:0] pair_reg  [m4vt_pkg::DIM][2];
    logic signed [PAIR_W-1:0] pair_next [m4vt_pkg::DIM][2];

    // Stage 3: result register.
    logic                     v3_reg, v3_next;
    logic signed [DW-1:0]     out_reg  [m4vt_pkg::DIM];
    logic signed [DW-1:0]     out_next [m4vt_pkg::DIM];

    logic signed [DW-1:0]     vec_in [m4vt_pkg::DIM];

    logic en1, en2, en3;
    logic cmd_acc;

    // Each stage loads when it is empty or its successor is loading.
    assign en3       = !v3_reg || !res_stall;
    assign en2       = !v2_reg || en3;
    assign en1       = !v1_reg || en2;
    assign cmd_stall = !en1;
    assign cmd_acc   = cmd_valid && en1;

    assign vec_in[0] = cmd.vec_x;
    assign vec_in[1] = cmd.vec_y;
    assign vec_in[2] = cmd.vec_z;
    assign vec_in[3] = cmd.vec_w;

    // Matrix update at acceptance; transforms read the value before this beat.
    always_comb
    begin
        for (int i = 0; i < m4vt_pkg::NELEM; i++)
        begin
            matrix_next[i] = matrix_reg[i];
        end
        if (cmd_acc && cmd.kind == m4vt_pkg::KIND_LOAD)
        begin
            matrix_next[{cmd.elem_row, cmd.elem_col}] = cmd.elem_value;
        end
        else if (cmd_acc && cmd.kind == m4vt_pkg::KIND_IDENT)
        begin
            for (int r = 0; r < m4vt_pkg::DIM; r++)
            begin
                for (int c = 0; c < m4vt_pkg::DIM; c++)
                begin
                    matrix_next[r * m4vt_pkg::DIM + c] = (r == c) ? m4vt_pkg::FIX_ONE : '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < m4vt_pkg::DIM; r++)
            begin
                for (int c = 0; c < m4vt_pkg::DIM; c++)
                begin
                    matrix_reg[r * m4vt_pkg::DIM + c] <= (r == c) ? m4vt_pkg::FIX_ONE : '0;
                end
            end
        end
        else
        begin
            matrix_reg <= matrix_next;
        end
    end

    // Stage 1: sixteen signed 32x32 products.
    always_comb
    begin
        for (int r = 0; r < m4vt_pkg::DIM; r++)
        begin
            for (int c = 0; c < m4vt_pkg::DIM; c++)
            begin
                prod_next[r][c] = PROD_W'(matrix_reg[r * m4vt_pkg::DIM + c])
                                * PROD_W'(vec_in[c]);
            end
        end
    end

    // Stage 2: two pair sums per row.
    always_comb
    begin
        for (int r = 0; r < m4vt_pkg::DIM; r++)
        begin
            for (int h = 0; h < 2; h++)
            begin
                pair_next[r][h] = PAIR_W'(prod_reg[r][2 * h])
                                + PAIR_W'(prod_reg[r][2 * h + 1]);
            end
        end
    end

    // Stage 3: final add, arithmetic shift (floor), saturate to 32 bits.
    always_comb
    begin
        logic signed [SUM_W-1:0] sum;
        logic signed [SUM_W-1:0] shifted;
        for (int r = 0; r < m4vt_pkg::DIM; r++)
        begin
            sum     = SUM_W'(pair_reg[r][0]) + SUM_W'(pair_reg[r][1]);
            shifted = sum >>> m4vt_pkg::FRAC_BITS;
            if (shifted > SAT_HI)
            begin
                out_next[r] = SAT_HI[DW-1:0];
            end
            else if (shifted < SAT_LO)
            begin
                out_next[r] = SAT_LO[DW-1:0];
            end
            else
            begin
                out_next[r] = shifted[DW-1:0];
            end
        end
    end

    // Valid bits follow the data; only transform beats occupy the pipeline.
    always_comb
    begin
        v1_next = en1 ? (cmd_acc && cmd.kind == m4vt_pkg::KIND_XFORM) : v1_reg;
        v2_next = en2 ? v1_reg : v2_reg;
        v3_next = en3 ? v2_reg : v3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            prod_reg <= prod_next;
        end
        if (en2)
        begin
            pair_reg <= pair_next;
        end
        if (en3)
        begin
            out_reg <= out_next;
        end
    end

    assign res_valid = v3_reg;
    assign res.out_x = out_reg[0];
    assign res.out_y = out_reg[1];
    assign res.out_z = out_reg[2];
    assign res.out_w = out_reg[3];

endmodule

`default_nettype wire

// ----- rtl/core/m4vt_checker.sv -----
// Port-level checker for the transform unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module m4vt_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           cmd_valid,
    input wire logic           cmd_stall,
    input wire m4vt_pkg::cmd_t cmd,
    input wire logic           res_valid,
    input wire logic           res_stall,
    input wire m4vt_pkg::res_t res
);

    logic xform_acc;
    assign xform_acc = cmd_valid && !cmd_stall && cmd.kind == m4vt_pkg::KIND_XFORM;

    // A stalled result beat stays and holds its payload.
    `M4VT_ASSERT_NXT(a_res_hold, clk, rst_n, res_valid && res_stall, res_valid, "res beat dropped")
    `M4VT_ASSERT_NXT(a_res_stable, clk, rst_n, res_valid && res_stall, $stable(res), "res changed")

    // Input backpressure only appears when the output is full and stalled.
    `M4VT_ASSERT_IMP(a_stall_src, clk, rst_n, cmd_stall, res_valid && res_stall, "bad stall")

    // An accepted transform reaches the output when nothing stalls.
    `M4VT_ASSERT_NXT(a_latency, clk, rst_n, xform_acc ##1 !res_stall ##1 !res_stall, res_valid, "lost beat")

endmodule

bind mat4_vector_transform_top m4vt_checker u_m4vt_checker (.*);

`default_nettype wire

// ----- test/mat4_vector_transform_top_tb.sv -----
// Self-checking testbench for the 4x4 matrix vector transform unit.
`timescale 1ns / 1ps

module mat4_vector_transform_top_tb;

    // Code 2'd3 on the kind field has no meaning; the block drops it.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam int TOTAL_BEATS = 1550;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_LIMIT = 5000;
    localparam int MAX_REPORTS = 10;

    localparam logic [m4vt_pkg::DATA_W-1:0] FIX_MAX = 32'h7FFFFFFF;
    localparam logic [m4vt_pkg::DATA_W-1:0] FIX_MIN = 32'h80000000;

    // Saturation bounds on the shifted 67-bit row sum.
    localparam logic signed [66:0] SUM_MAX = 67'sh7FFFFFFF;
    localparam logic signed [66:0] SUM_MIN = -67'sh80000000;

    typedef struct {
        m4vt_pkg::cmd_t c;
        bit             lit_on;
        m4vt_pkg::res_t lit;
    } stim_row_t;

    logic           clk = 1'b0;
    logic           rst_n;
    logic           cmd_valid;
    logic           cmd_stall;
    m4vt_pkg::cmd_t cmd;
    logic           res_valid;
    logic           res_stall;
    m4vt_pkg::res_t res;

    // Typed-in expectation, travels with the command beat.
    logic           lit_on_q;
    m4vt_pkg::res_t lit_q;

    // Shadow copy of the matrix, index row*4+col.
    logic signed [m4vt_pkg::DATA_W-1:0] mat_shadow [m4vt_pkg::NELEM];
    m4vt_pkg::res_t xform_due [$];

    int  n_err     = 0;
    int  cycle_cnt = 0;
    int  n_sent    = 0;
    bit  hold_go   = 1'b0;

    mat4_vector_transform_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    always #6 clk = ~clk;

    // Hard stop in case the pipeline locks up.
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic void set_identity();
        int i;
        for (i = 0; i < m4vt_pkg::NELEM; i++)
            mat_shadow[i] = (i % 5 == 0) ? m4vt_pkg::FIX_ONE : '0;
    endfunction

    // Row r of the result: exact sum of four 64-bit products, arithmetic shift
    // (floor), then clamp to 32 bits.
    function automatic m4vt_pkg::res_t transform_vec(input m4vt_pkg::cmd_t c);
        logic signed [66:0]            vec [m4vt_pkg::DIM];
        logic signed [66:0]            elem;
        logic signed [66:0]            acc;
        logic signed [66:0]            q;
        logic [m4vt_pkg::DATA_W-1:0]   o [m4vt_pkg::DIM];
        int r;
        int k;
        vec[0] = 67'(c.vec_x);
        vec[1] = 67'(c.vec_y);
        vec[2] = 67'(c.vec_z);
        vec[3] = 67'(c.vec_w);
        for (r = 0; r < m4vt_pkg::DIM; r++)
        begin
            acc = '0;
            for (k = 0; k < m4vt_pkg::DIM; k++)
            begin
                elem = 67'(mat_shadow[r * m4vt_pkg::DIM + k]);
                acc  = acc + elem * vec[k];
            end
            q = acc >>> m4vt_pkg::FRAC_BITS;
            if (q > SUM_MAX)
                o[r] = FIX_MAX;
            else if (q < SUM_MIN)
                o[r] = FIX_MIN;
            else
                o[r] = q[m4vt_pkg::DATA_W-1:0];
        end
        return m4vt_pkg::res_t'{o[0], o[1], o[2], o[3]};
    endfunction

    // Half full range, many small values (within +-8.0), some extremes.
    function automatic logic [m4vt_pkg::DATA_W-1:0] rand_fix();
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 4))
                    0:       return FIX_MAX;
                    1:       return FIX_MIN;
                    2:       return '0;
                    3:       return 32'hFFFFFFFF;
                    default: return m4vt_pkg::FIX_ONE;
                endcase
            end
            1, 2, 3, 4: return $urandom_range(0, 32'h000FFFFF) - 32'h00080000;
            default:    return $urandom();
        endcase
    endfunction

    // Every field but kind is randomized, used or not, so all input bits toggle.
    function automatic m4vt_pkg::cmd_t rand_cmd(input logic [1:0] k);
        m4vt_pkg::cmd_t c;
        c.kind       = k;
        c.elem_row   = 2'($urandom_range(0, 3));
        c.elem_col   = 2'($urandom_range(0, 3));
        c.elem_value = rand_fix();
        c.vec_x      = rand_fix();
        c.vec_y      = rand_fix();
        c.vec_z      = rand_fix();
        c.vec_w      = rand_fix();
        return c;
    endfunction

    function automatic m4vt_pkg::cmd_t mk(input logic [1:0] k, input int r,
                                          input int cl, input logic [31:0] v,
                                          input logic [31:0] x, input logic [31:0] y,
                                          input logic [31:0] z, input logic [31:0] w);
        return m4vt_pkg::cmd_t'{k, 2'(r), 2'(cl), v, x, y, z, w};
    endfunction

    // Sender gap: mostly none, some short, a few long. The first hundred
    // beats of every five hundred go back to back.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (n_sent % 500 < 100)
            return 0;
        if (r < 60)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Hold the beat until the edge that takes it.
    task automatic send_beat(input m4vt_pkg::cmd_t c, input bit lit_on,
                             input m4vt_pkg::res_t lit);
        cmd_valid <= 1'b1;
        cmd       <= c;
        lit_on_q  <= lit_on;
        lit_q     <= lit;
        do
            @(posedge clk);
        while (!(cmd_valid && !cmd_stall));
        if (c.kind != KIND_UNUSED)
            n_sent++;
    endtask

    task automatic idle_gap();
        int g;
        g = pick_gap();
        if (g > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // Scoreboard: results are checked before the same edge's command updates
    // the shadow matrix; a result is always older than any command at its edge.
    always @(posedge clk)
    begin
        m4vt_pkg::res_t want;
        if (!rst_n)
        begin
            set_identity();
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (xform_due.size() == 0)
                begin
                    n_err++;
                    if (n_err <= MAX_REPORTS)
                        $display("unexpected result beat %h", res);
                end
                else
                begin
                    want = xform_due.pop_front();
                    if (res.out_x !== want.out_x || res.out_y !== want.out_y ||
                        res.out_z !== want.out_z || res.out_w !== want.out_w)
                    begin
                        n_err++;
                        if (n_err <= MAX_REPORTS)
                            $display("mismatch: exp x %h y %h z %h w %h, got x %h y %h z %h w %h",
                                     want.out_x, want.out_y, want.out_z, want.out_w,
                                     res.out_x, res.out_y, res.out_z, res.out_w);
                    end
                end
            end
            if (cmd_valid && !cmd_stall)
            begin
                case (cmd.kind)
                    m4vt_pkg::KIND_LOAD:
                        mat_shadow[{cmd.elem_row, cmd.elem_col}] = cmd.elem_value;
                    m4vt_pkg::KIND_IDENT:
                        set_identity();
                    m4vt_pkg::KIND_XFORM:
                        xform_due.push_back(lit_on_q ? lit_q : transform_vec(cmd));
                    default:    ; // unused code, dropped by the block
                endcase
            end
        end
    end

    // Result side stall pattern, plus one long hold-off that backs the
    // pipeline up into cmd_stall while the sender keeps offering beats.
    initial
    begin
        int  r;
        int  d;
        bit  v;
        bit  held;
        held = 1'b0;
        res_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_go && !held)
            begin
                held = 1'b1;
                v    = 1'b1;
                d    = HOLD_CYCLES;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 45)
                begin
                    v = 1'b0;
                    d = $urandom_range(1, 6);
                end
                else if (r < 75)
                begin
                    v = 1'b1;
                    d = $urandom_range(1, 3);
                end
                else if (r < 80)
                begin
                    v = 1'b1;
                    d = $urandom_range(10, 40);
                end
                else
                begin
                    v = 1'b0;
                    d = $urandom_range(20, 80);
                end
            end
            res_stall <= v;
            repeat (d) @(posedge clk);
        end
    end

    // Stimulus
    initial
    begin
        stim_row_t       rows [$];
        m4vt_pkg::cmd_t  c;
        int              pick;
        int              i;
        int              waited;
        bit              drained;
        logic [1:0]      k;

        drained   = 1'b0;
        rst_n     <= 1'b0;
        cmd_valid <= 1'b0;
        cmd       <= '0;
        lit_on_q  <= 1'b0;
        lit_q     <= '0;

        // Directed table. Expected values are typed in where the matrix is
        // identity or the sums saturate; the rest go through the predictor.
        // Identity after reset passes the vector through.
        rows.push_back('{mk(m4vt_pkg::KIND_XFORM, 0, 0, 0, m4vt_pkg::FIX_ONE, 32'h00020000,
                            32'hFFFD0000, FIX_MAX),
                         1'b1, m4vt_pkg::res_t'{m4vt_pkg::FIX_ONE, 32'h00020000,
                                                32'hFFFD0000, FIX_MAX}});
        rows.push_back('{mk(m4vt_pkg::KIND_XFORM, 0, 0, 0, FIX_MIN, FIX_MAX, 0, 32'hFFFFFFFF),
                         1'b1, m4vt_pkg::res_t'{FIX_MIN, FIX_MAX, 0, 32'hFFFFFFFF}});
        // Unused kind: must leave the matrix alone and give no result.
        rows.push_back('{mk(KIND_UNUSED, 3, 3, 32'hDEADBEEF, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN),
                         1'b0, m4vt_pkg::res_t'('0)});
        rows.push_back('{mk(m4vt_pkg::KIND_XFORM, 0, 0, 0, 1, 0, 0, 0),
                         1'b1, m4vt_pkg::res_t'{1, 0, 0, 0}});
        // Row 0 all max: positive and negative overflow on out_x.
        for (i = 0; i < m4vt_pkg::DIM; i++)
            rows.push_back('{mk(m4vt_pkg::KIND_LOAD, 0, i, FIX_MAX, 0, 0, 0, 0),
                             1'b0, m4vt_pkg::res_t'('0)});
        rows.push_back('{mk(m4vt_pkg::KIND_XFORM, 0, 0, 0, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX),
                         1'b1, m4vt_pkg::res_t'{FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX}});
        rows.push_back('{mk(m4vt_pkg::KIND_XFORM, 0, 0, 0, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN),
                         1'b1, m4vt_pkg::res_t'{FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN}});
        // Row 1 all min: min*min four times is the widest sum there is.
        for (i = 0; i < m4vt_pkg::DIM; i++)
            rows.push_back('{mk(m4vt_pkg::KIND_LOAD, 1, i, FIX_MIN, 0, 0, 0, 0),
                             1'b0, m4vt_pkg::res_t'('0)});
        rows.push_back('{mk(m4vt_pkg::KIND_XFORM, 0, 0, 0, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN),
                         1'b1, m4vt_pkg::res_t'{FIX_MIN, FIX_MAX, FIX_MIN, FIX_MIN}});
        rows.push_back('{mk(m4vt_pkg::KIND_IDENT, 0, 0, 0, 0, 0, 0, 0),
                         1'b0, m4vt_pkg::res_t'('0)});
        rows.push_back('{mk(m4vt_pkg::KIND_XFORM, 0, 0, 0, FIX_MAX, FIX_MIN, 1, 32'hFFFFFFFF),
                         1'b1, m4vt_pkg::res_t'{FIX_MAX, FIX_MIN, 1, 32'hFFFFFFFF}});
        // Odd elements in rows 2 and 3: floor rounding of small negative terms.
        rows.push_back('{mk(m4vt_pkg::KIND_LOAD, 2, 3, 32'hFFFFFFFF, 0, 0, 0, 0),
                         1'b0, m4vt_pkg::res_t'('0)});
        rows.push_back('{mk(m4vt_pkg::KIND_LOAD, 3, 0, 32'h00008000, 0, 0, 0, 0),
                         1'b0, m4vt_pkg::res_t'('0)});
        rows.push_back('{mk(m4vt_pkg::KIND_LOAD, 3, 2, FIX_MIN, 0, 0, 0, 0),
                         1'b0, m4vt_pkg::res_t'('0)});
        rows.push_back('{mk(m4vt_pkg::KIND_XFORM, 0, 0, 0, 32'h00030001, m4vt_pkg::FIX_ONE,
                            1, 1),
                         1'b0, m4vt_pkg::res_t'('0)});
        rows.push_back('{mk(m4vt_pkg::KIND_XFORM, 0, 0, 0, 32'hFFFF0000, 32'h12345678,
                            FIX_MIN, FIX_MAX),
                         1'b0, m4vt_pkg::res_t'('0)});
        rows.push_back('{mk(m4vt_pkg::KIND_IDENT, 0, 0, 0, 0, 0, 0, 0),
                         1'b0, m4vt_pkg::res_t'('0)});

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[j])
        begin
            send_beat(rows[j].c, rows[j].lit_on, rows[j].lit);
            idle_gap();
        end

        // Random part: runs of transforms against matrices built from
        // single loads and full 16-element fills.
        while (n_sent < TOTAL_BEATS)
        begin
            if (n_sent >= 500 && !hold_go)
                hold_go = 1'b1;
            if (n_sent >= 1000 && !drained)
            begin
                // Sender pause until the pipeline is empty.
                drained = 1'b1;
                cmd_valid <= 1'b0;
                do
                    @(posedge clk);
                while (xform_due.size() != 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 10)
            begin
                for (i = 0; i < m4vt_pkg::NELEM; i++)
                begin
                    c = rand_cmd(m4vt_pkg::KIND_LOAD);
                    c.elem_row = 2'(i / m4vt_pkg::DIM);
                    c.elem_col = 2'(i % m4vt_pkg::DIM);
                    send_beat(c, 1'b0, m4vt_pkg::res_t'('0));
                    idle_gap();
                end
            end
            else
            begin
                if (pick < 30)
                    k = m4vt_pkg::KIND_LOAD;
                else if (pick < 33)
                    k = m4vt_pkg::KIND_IDENT;
                else if (pick < 36)
                    k = KIND_UNUSED;
                else
                    k = m4vt_pkg::KIND_XFORM;
                send_beat(rand_cmd(k), 1'b0, m4vt_pkg::res_t'('0));
                idle_gap();
            end
        end

        // Drain, then keep watching for stray results before the final check.
        cmd_valid <= 1'b0;
        waited = 0;
        do
        begin
            @(posedge clk);
            waited++;
        end
        while (xform_due.size() != 0 && waited < DRAIN_LIMIT);
        repeat (10) @(posedge clk);
        if (xform_due.size() != 0)
        begin
            n_err += xform_due.size();
            $display("%0d transform results never arrived", xform_due.size());
        end

        if (n_err == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
